/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared transaction types, operation codes and controller commands.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CFG_BITS   = 4;
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 32;
    localparam logic [CFG_BITS-1:0] CAP_RESET = 4'd5;

    localparam logic [1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_REFRESH = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   lookup_key;
        logic [VALUE_W-1:0] backing_value;
        logic               backing_found;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic               value_valid;
        logic               was_hit;
        logic               did_evict;
    } out_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic exec;
    } cmd_t;

endpackage

/* hdl/lkvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences each transaction through capture, tag match and update, and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output lkvc_pkg::cmd_t cmd
);
    import lkvc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.match  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* hdl/lkvc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry lanes with tag compare, recency ranks, occupancy count, capacity
// register and the result register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lkvc_pkg::cmd_t                cmd,
    input  lkvc_pkg::in_t                 s_data,
    input  logic                          cfg_wr_en,
    input  logic [lkvc_pkg::CFG_BITS-1:0] cfg_wr_data,
    output lkvc_pkg::out_t                m_data
);
    import lkvc_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    in_t                 item_reg;
    out_t                out_reg, out_next;
    logic [CFG_BITS-1:0] cap_cfg_reg;

    logic [KEY_BITS-1:0] key_reg   [ENTRIES];
    logic [KEY_BITS-1:0] key_next  [ENTRIES];
    logic [VALUE_W-1:0]  value_reg [ENTRIES];
    logic [VALUE_W-1:0]  value_next[ENTRIES];
    logic [RANK_W-1:0]   rank_reg  [ENTRIES];
    logic [RANK_W-1:0]   rank_next [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                hit_reg, hit_next;
    logic [ENTRIES-1:0]  hit_vec_reg, hit_vec_next;
    logic [VALUE_W-1:0]  hit_value_reg, hit_value_next;
    logic [RANK_W-1:0]   hit_rank_reg, hit_rank_next;
    logic [ENTRIES-1:0]  lru_vec_reg, lru_vec_next;
    logic [ENTRIES-1:0]  ins_vec_reg, ins_vec_next;
    logic                full_reg, full_next;

    logic [CNT_W-1:0]    count_m1;
    logic [CMP_W-1:0]    cap_eff;
    logic [ENTRIES-1:0]  cand;
    logic                do_promote, do_drop, do_insert, do_write;

    // Tag match, LRU victim and free slot selection.
    always_comb begin
        count_m1       = count_reg - CNT_W'(1);
        hit_vec_next   = '0;
        lru_vec_next   = '0;
        hit_value_next = '0;
        hit_rank_next  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec_next[i] = valid_reg[i] &&
                              (key_reg[i] == item_reg.lookup_key[KEY_BITS-1:0]);
            lru_vec_next[i] = valid_reg[i] && (rank_reg[i] == count_m1[RANK_W-1:0]);
            hit_value_next  = hit_value_next | (hit_vec_next[i] ? value_reg[i] : '0);
            hit_rank_next   = hit_rank_next | (hit_vec_next[i] ? rank_reg[i] : '0);
        end
        hit_next = |hit_vec_next;
        cap_eff  = CMP_W'(cap_cfg_reg);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
        full_next    = CMP_W'(count_reg) >= cap_eff;
        cand         = ~valid_reg | (full_next ? lru_vec_next : '0);
        ins_vec_next = cand & (~cand + ENTRIES'(1));
    end

    // Operation decode and result.
    always_comb begin
        do_promote = 1'b0;
        do_drop    = 1'b0;
        do_insert  = 1'b0;
        do_write   = 1'b0;
        out_next   = '0;
        out_next.was_hit = hit_reg;
        case (item_reg.kind)
            KIND_LOOKUP: begin
                if (hit_reg) begin
                    do_promote           = 1'b1;
                    out_next.value_out   = hit_value_reg;
                    out_next.value_valid = 1'b1;
                end else if (item_reg.backing_found) begin
                    do_insert            = 1'b1;
                    out_next.value_out   = item_reg.backing_value;
                    out_next.value_valid = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (hit_reg) begin
                    do_write   = 1'b1;
                    do_promote = 1'b1;
                end else begin
                    do_insert = 1'b1;
                end
                out_next.value_out   = item_reg.backing_value;
                out_next.value_valid = 1'b1;
            end
            KIND_REMOVE: begin
                if (hit_reg) begin
                    do_drop              = 1'b1;
                    out_next.value_out   = hit_value_reg;
                    out_next.value_valid = 1'b1;
                end
            end
            KIND_REFRESH: begin
                if (hit_reg) begin
                    if (hit_value_reg != item_reg.backing_value) begin
                        do_write   = 1'b1;
                        do_promote = 1'b1;
                    end
                    out_next.value_out   = item_reg.backing_value;
                    out_next.value_valid = 1'b1;
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
        out_next.did_evict = do_insert && full_reg;
        do_promote = do_promote && cmd.exec;
        do_drop    = do_drop && cmd.exec;
        do_insert  = do_insert && cmd.exec;
        do_write   = do_write && cmd.exec;
    end

    // Per-entry state update.
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            rank_next[i]  = rank_reg[i];
            if (do_write && hit_vec_reg[i]) begin
                value_next[i] = item_reg.backing_value;
            end
            if (do_promote) begin
                if (hit_vec_reg[i]) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg)) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (do_drop) begin
                if (hit_vec_reg[i]) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end else if (valid_reg[i] && (rank_reg[i] > hit_rank_reg)) begin
                    rank_next[i] = rank_reg[i] - RANK_W'(1);
                end
            end
            if (do_insert) begin
                if (ins_vec_reg[i]) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                    key_next[i]   = item_reg.lookup_key[KEY_BITS-1:0];
                    value_next[i] = item_reg.backing_value;
                end else if (full_reg && lru_vec_reg[i]) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (do_drop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (do_insert && !full_reg) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            count_reg   <= '0;
            cap_cfg_reg <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg_wr_en) begin
                cap_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
        end
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.match) begin
            hit_reg       <= hit_next;
            hit_vec_reg   <= hit_vec_next;
            hit_value_reg <= hit_value_next;
            hit_rank_reg  <= hit_rank_next;
            lru_vec_reg   <= lru_vec_next;
            ins_vec_reg   <= ins_vec_next;
            full_reg      <= full_next;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

/* hdl/lru_key_value_cache_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-to-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) carries one operation per
// transaction: lookup, write, remove or refresh of a key. The result channel
// (m_valid, m_ready, m_data) returns exactly one result per operation, in
// order. The capacity register is written through cfg_wr_en and cfg_wr_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce; a write while idle takes effect on the next operation.
// An operation is captured at the accepting edge, its tag match across all
// entries is registered in the match state, and the exec state updates the
// entry lanes and loads the result register. One operation is in flight at a
// time, so no new operation is accepted until the current one is updated.
// A finished result waits in the output register; the next operation is
// accepted and matched meanwhile, and its update waits until the receiver
// takes the pending result. Reset empties the cache, sets the capacity to
// five entries and drops any pending result.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lkvc_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lkvc_pkg::out_t                m_data,
    input  logic                          cfg_wr_en,
    input  logic [lkvc_pkg::CFG_BITS-1:0] cfg_wr_data
);
    import lkvc_pkg::*;

    cmd_t cmd;

    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lkvc_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while an operation was in flight.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.did_evict |-> m_data.value_valid && !m_data.was_hit)
        else $error("Eviction reported without an insertion.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.value_valid |-> m_data.value_out == '0)
        else $error("Invalid result carries a nonzero value.");

endmodule
